>>> rtl/ptme_pkg.sv
// ----------------------------------------------------------------------------
// ptme_pkg
// shared types, constants and helpers for the page table map/unmap engine
// ----------------------------------------------------------------------------
package ptme_pkg;

  localparam int unsigned POOL_PAGES_DEF    = 64;
  localparam int unsigned ENTRIES_PER_TABLE = 512;
  localparam int unsigned IDX_W             = 9;
  localparam int unsigned VA_W              = 57;
  localparam int unsigned LVL_W             = 3;

  localparam logic [63:0] FRAME_BITS = 64'h7FFF_FFFF_FFFF_F000;
  localparam logic [63:0] FLAG_P     = 64'h1;
  localparam logic [63:0] FLAG_RW    = 64'h2;
  localparam logic [63:0] FLAG_WT    = 64'h8;

  localparam logic [LVL_W-1:0] LEVELS_RESET = 3'd4;
  localparam logic [LVL_W-1:0] LEVELS_FIVE  = 3'd5;
  localparam logic [LVL_W-1:0] LEVELS_FOUR  = 3'd4;
  localparam logic [LVL_W-1:0] LVL_LEAF     = 3'd1;
  localparam logic [LVL_W-1:0] LVL_LAST_TBL = 3'd2;

  // register indexes
  localparam logic REG_LEVELS = 1'b0;

  localparam logic REQ_MAP   = 1'b0;
  localparam logic REQ_UNMAP = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [63:0] virt_addr;
    logic [63:0] phys_addr;
    logic        writable;
    logic        write_through;
  } req_t;

  typedef struct packed {
    logic            ok;
    logic            invalidate;
    logic [VA_W-1:0] invalidate_addr;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_ALLOC,
    ST_LINK,
    ST_LEAF,
    ST_RESP
  } state_t;

  // 9-bit table index of a virtual address at a given level
  function automatic logic [IDX_W-1:0] level_index(input logic [VA_W-1:0] va,
                                                   input logic [LVL_W-1:0] lvl);
    logic [IDX_W-1:0] idx;
    unique case (lvl)
      3'd1:    idx = va[20:12];
      3'd2:    idx = va[29:21];
      3'd3:    idx = va[38:30];
      3'd4:    idx = va[47:39];
      3'd5:    idx = va[56:48];
      default: idx = '0;
    endcase
    return idx;
  endfunction

endpackage

>>> rtl/ptme_ram.sv
// ----------------------------------------------------------------------------
// ptme_ram
// generic simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module ptme_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/page_table_map_unmap_engine_top.sv
// ----------------------------------------------------------------------------
// page_table_map_unmap_engine_top
// map/unmap requests walked over x86_64 radix tables held in a local page pool
// ----------------------------------------------------------------------------
// walk: a read and an evaluate step per table level walked, then the leaf write and
//   the result load; each new table adds a clear of its 512 entries and a link write
// throughput: one request at a time, the next beat is taken in the cycle after the
//   result is loaded, and the load waits while the output holds an untaken beat
// reset: synchronous, then a sweep clears the whole pool, POOL_PAGES*512 entries
//   (32768 by default), during which no request beat is taken
// ----------------------------------------------------------------------------
module page_table_map_unmap_engine_top
  import ptme_pkg::*;
#(
  parameter int unsigned POOL_PAGES = POOL_PAGES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  req_t        in_data,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output rsp_t        out_data,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // pool geometry: address is {page, index}
  localparam int unsigned PW    = $clog2(POOL_PAGES);
  localparam int unsigned NFW   = $clog2(POOL_PAGES + 1);
  localparam int unsigned DEPTH = POOL_PAGES * ENTRIES_PER_TABLE;
  localparam int unsigned AW    = PW + IDX_W;

  // sequencer state
  state_t           state_r, state_nxt;
  logic [LVL_W-1:0] lvl_r, lvl_nxt;
  logic [PW-1:0]    page_r, page_nxt;
  logic [PW-1:0]    fresh_r, fresh_nxt;
  logic [AW-1:0]    sweep_r, sweep_nxt;
  logic [NFW-1:0]   next_free_r, next_free_nxt;
  req_t             req_r, req_nxt;
  rsp_t             res_r, res_nxt;
  logic             out_valid_r, out_valid_nxt;
  rsp_t             out_data_r, out_data_nxt;
  logic [LVL_W-1:0] levels_r, levels_nxt;

  // pool ram port
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [63:0]      ram_wdata;
  logic             ram_re;
  logic [AW-1:0]    ram_raddr;
  logic [63:0]      ram_rdata;

  // walk helpers
  logic             five;
  logic [VA_W-1:0]  va_in;
  logic [IDX_W-1:0] cur_idx;
  logic [IDX_W-1:0] leaf_idx;
  logic [63:0]      flags;
  logic             ent_zero;
  logic             ent_outside;
  logic [PW-1:0]    ent_page;
  logic             pool_full;
  logic             cfg_wr;

  ptme_ram #(
    .WIDTH (64),
    .DEPTH (DEPTH)
  ) u_pool (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // 5 levels selects 57-bit addresses, any other value acts as 4 levels
  assign five  = (levels_r == LEVELS_FIVE);
  assign va_in = five ? in_data.virt_addr[VA_W-1:0]
                      : {9'd0, in_data.virt_addr[47:0]};

  assign cur_idx  = level_index(req_r.virt_addr[VA_W-1:0], lvl_r);
  assign leaf_idx = level_index(req_r.virt_addr[VA_W-1:0], LVL_LEAF);

  // requested leaf and link flags: P always, RW and WT on request
  assign flags = FLAG_P
               | (req_r.writable      ? FLAG_RW : 64'd0)
               | (req_r.write_through ? FLAG_WT : 64'd0);

  // decode of the table entry just read
  assign ent_zero    = (ram_rdata == 64'd0);
  assign ent_outside = (ram_rdata[62:12] >= 51'(POOL_PAGES));
  assign ent_page    = ram_rdata[12 +: PW];
  assign pool_full   = (next_free_r >= NFW'(POOL_PAGES));

  // config write lands in the access phase
  assign cfg_wr = psel & penable & pwrite;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_LEVELS) ? {29'd0, levels_r} : 32'd0;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      sweep_r     <= '0;
      next_free_r <= NFW'(1);
      out_valid_r <= 1'b0;
      levels_r    <= LEVELS_RESET;
    end else begin
      state_r     <= state_nxt;
      sweep_r     <= sweep_nxt;
      next_free_r <= next_free_nxt;
      out_valid_r <= out_valid_nxt;
      levels_r    <= levels_nxt;
    end
  end

  // payload and walk context, no reset needed
  always_ff @(posedge clk) begin
    lvl_r      <= lvl_nxt;
    page_r     <= page_nxt;
    fresh_r    <= fresh_nxt;
    req_r      <= req_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    lvl_nxt       = lvl_r;
    page_nxt      = page_r;
    fresh_nxt     = fresh_r;
    sweep_nxt     = sweep_r;
    next_free_nxt = next_free_r;
    req_nxt       = req_r;
    res_nxt       = res_r;
    out_data_nxt  = out_data_r;
    levels_nxt    = levels_r;
    ram_we        = 1'b0;
    ram_waddr     = {page_r, cur_idx};
    ram_wdata     = 64'd0;
    ram_re        = 1'b0;
    ram_raddr     = {page_r, cur_idx};

    // result beat leaves the output register
    out_valid_nxt = out_valid_r & ~out_ready;

    if (cfg_wr && paddr[2] == REG_LEVELS) begin
      levels_nxt = pwdata[LVL_W-1:0];
    end

    unique case (state_r)
      // post-reset sweep of the whole pool
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_r;
        ram_wdata = 64'd0;
        sweep_nxt = sweep_r + AW'(1);
        if (sweep_r == AW'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_valid) begin
          req_nxt           = in_data;
          req_nxt.virt_addr = {7'd0, va_in};
          lvl_nxt           = five ? LEVELS_FIVE : LEVELS_FOUR;
          page_nxt          = '0;
          state_nxt         = ST_READ;
        end
      end

      ST_READ: begin
        ram_re    = 1'b1;
        state_nxt = ST_EVAL;
      end

      ST_EVAL: begin
        if (req_r.req_type == REQ_MAP) begin
          if (!ent_zero) begin
            // present table without RW gets RW on a writable map, WT dropped
            if (req_r.writable && !ram_rdata[1]) begin
              ram_we    = 1'b1;
              ram_wdata = (ram_rdata & FRAME_BITS) | FLAG_P | FLAG_RW;
            end
            if (ent_outside) begin
              res_nxt   = '0;
              state_nxt = ST_RESP;
            end else begin
              page_nxt = ent_page;
              if (lvl_r == LVL_LAST_TBL) begin
                state_nxt = ST_LEAF;
              end else begin
                lvl_nxt   = lvl_r - LVL_W'(1);
                state_nxt = ST_READ;
              end
            end
          end else if (pool_full) begin
            res_nxt   = '0;
            state_nxt = ST_RESP;
          end else begin
            fresh_nxt     = next_free_r[PW-1:0];
            next_free_nxt = next_free_r + NFW'(1);
            sweep_nxt     = '0;
            state_nxt     = ST_ALLOC;
          end
        end else begin
          if (ent_zero) begin
            // nothing mapped, no invalidate
            res_nxt    = '0;
            res_nxt.ok = 1'b1;
            state_nxt  = ST_RESP;
          end else if (ent_outside) begin
            res_nxt   = '0;
            state_nxt = ST_RESP;
          end else begin
            page_nxt = ent_page;
            if (lvl_r == LVL_LAST_TBL) begin
              state_nxt = ST_LEAF;
            end else begin
              lvl_nxt   = lvl_r - LVL_W'(1);
              state_nxt = ST_READ;
            end
          end
        end
      end

      // clear the newly taken table before linking it
      ST_ALLOC: begin
        ram_we    = 1'b1;
        ram_waddr = {fresh_r, sweep_r[IDX_W-1:0]};
        ram_wdata = 64'd0;
        sweep_nxt = sweep_r + AW'(1);
        if (sweep_r[IDX_W-1:0] == IDX_W'(ENTRIES_PER_TABLE - 1)) begin
          state_nxt = ST_LINK;
        end
      end

      ST_LINK: begin
        ram_we    = 1'b1;
        ram_wdata = ((64'(fresh_r) << 12) & FRAME_BITS) | flags;
        page_nxt  = fresh_r;
        if (lvl_r == LVL_LAST_TBL) begin
          state_nxt = ST_LEAF;
        end else begin
          lvl_nxt   = lvl_r - LVL_W'(1);
          state_nxt = ST_READ;
        end
      end

      ST_LEAF: begin
        ram_we    = 1'b1;
        ram_waddr = {page_r, leaf_idx};
        ram_wdata = (req_r.req_type == REQ_MAP) ? (req_r.phys_addr | flags) : 64'd0;
        res_nxt.ok              = 1'b1;
        res_nxt.invalidate      = 1'b1;
        res_nxt.invalidate_addr = req_r.virt_addr[VA_W-1:0];
        state_nxt               = ST_RESP;
      end

      // hand the result to the output register once it is free
      ST_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_data_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

>>> test/tb_page_table_map_unmap_engine_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_page_table_map_unmap_engine_top
// self-checking bench for the map/unmap walker: a directed table of requests
// (empty tables, address extremes, rw upgrade, walks through a leaf after a
// level change) followed by random phases under several level settings, with
// hot table indices so that walks share tables and the pool runs dry. each
// result beat is checked against an in-bench copy of the page tables
// ----------------------------------------------------------------------------
module tb_page_table_map_unmap_engine_top;
  import ptme_pkg::*;

  localparam int unsigned PAGE_COUNT   = POOL_PAGES_DEF;
  localparam int unsigned LIMIT_CYCLES = 1000000;
  localparam int unsigned PHASE_ITEMS  = 50;
  localparam int unsigned NUM_PHASES   = 9;
  localparam logic [63:0] VA48_MASK    = 64'h0000_FFFF_FFFF_FFFF;
  localparam logic [63:0] VA57_MASK    = 64'h01FF_FFFF_FFFF_FFFF;

  // one row of the directed table; levels_sel < 0 keeps the current setting
  typedef struct {
    int   levels_sel;
    req_t rq;
    logic fixed;
    rsp_t fixed_rsp;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  req_t        in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  rsp_t        out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // shadow of the table pool and allocator, updated at every accepted request beat
  logic [63:0] tbl_pool [0:PAGE_COUNT*ENTRIES_PER_TABLE-1];
  int unsigned next_page = 1;
  logic [2:0]  levels_shadow = LEVELS_RESET;

  rsp_t        walk_outcomes [$];
  logic [63:0] mapped_vas [$];
  plan_row_t   directed_plan [$];

  logic        steady_flow = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned error_count = 0;
  int unsigned maps_sent = 0;
  int unsigned unmaps_sent = 0;
  int unsigned invalidates_seen = 0;
  int unsigned failed_walks = 0;
  int unsigned level_writes = 0;

  page_table_map_unmap_engine_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // watchdog: the reset sweep, every table allocation and all gaps fit many times over
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic report_failure(input string what);
    error_count++;
    if (error_count <= 10) $display("mismatch at %0t: %s", $realtime, what);
  endtask

  // flat pool slot of the entry that a given level of the walk touches
  function automatic int unsigned table_slot(input int unsigned page, input logic [63:0] va,
                                             input int lvl);
    logic [63:0] idx;
    idx = (va >> (3 + 9 * lvl)) & 64'h1FF;
    return page * ENTRIES_PER_TABLE + int'(idx);
  endfunction

  // walks the shadow tables for one request and returns the result it must give
  function automatic rsp_t walk_request(input req_t rq);
    rsp_t        res;
    logic        five;
    int          lvl;
    int unsigned page;
    int unsigned slot;
    logic [63:0] va;
    logic [63:0] flags;
    logic [63:0] link;
    res   = '0;
    five  = (levels_shadow == LEVELS_FIVE);
    va    = rq.virt_addr & (five ? VA57_MASK : VA48_MASK);
    page  = 0;
    flags = FLAG_P | (rq.writable ? FLAG_RW : 64'h0) | (rq.write_through ? FLAG_WT : 64'h0);
    for (lvl = five ? 5 : 4; lvl > 1; lvl--) begin
      slot = table_slot(page, va, lvl);
      link = tbl_pool[slot];
      if (link == 64'h0) begin
        // unmap of an address that was never mapped: nothing written
        if (rq.req_type == REQ_UNMAP) begin
          res.ok = 1'b1;
          return res;
        end
        // pool exhausted: links made earlier in this walk stay
        if (next_page >= PAGE_COUNT) return res;
        for (int e = 0; e < ENTRIES_PER_TABLE; e++) tbl_pool[next_page * ENTRIES_PER_TABLE + e] = '0;
        tbl_pool[slot] = ((64'(next_page) << 12) & FRAME_BITS) | flags;
        page = next_page;
        next_page++;
      end else begin
        // read-only table on a writable map gains rw, write-through is dropped
        if (rq.req_type == REQ_MAP && rq.writable && (link & FLAG_RW) == 64'h0) begin
          link = (link & FRAME_BITS) | FLAG_P | FLAG_RW;
          tbl_pool[slot] = link;
        end
        // entry whose frame lies outside the pool ends the request
        if (((link & FRAME_BITS) >> 12) >= 64'(PAGE_COUNT)) return res;
        page = int'((link & FRAME_BITS) >> 12);
      end
    end
    slot = table_slot(page, va, 1);
    tbl_pool[slot] = (rq.req_type == REQ_MAP) ? (rq.phys_addr | flags) : 64'h0;
    res.ok              = 1'b1;
    res.invalidate      = 1'b1;
    res.invalidate_addr = va[VA_W-1:0];
    return res;
  endfunction

  function automatic void add_row(input int lv, input logic kind, input logic [63:0] va,
                                  input logic [63:0] pa, input logic w, input logic wt,
                                  input logic fixed, input logic ok, input logic inv,
                                  input logic [VA_W-1:0] addr);
    plan_row_t row;
    row.levels_sel              = lv;
    row.rq.req_type             = kind;
    row.rq.virt_addr            = va;
    row.rq.phys_addr            = pa;
    row.rq.writable             = w;
    row.rq.write_through        = wt;
    row.fixed                   = fixed;
    row.fixed_rsp.ok            = ok;
    row.fixed_rsp.invalidate    = inv;
    row.fixed_rsp.invalidate_addr = addr;
    directed_plan.push_back(row);
  endfunction

  // four index values per upper level so that random walks share tables
  function automatic logic [8:0] hot_index();
    case ($urandom_range(0, 3))
      0: return 9'd0;
      1: return 9'd1;
      2: return 9'd256;
      default: return 9'd511;
    endcase
  endfunction

  function automatic req_t draw_request();
    req_t        rq;
    int unsigned pick;
    rq.req_type      = ($urandom_range(0, 9) < 6) ? REQ_MAP : REQ_UNMAP;
    rq.phys_addr     = {$urandom, $urandom};
    rq.writable      = 1'($urandom);
    rq.write_through = 1'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      // noise: any address at all, mostly fresh tables
      rq.virt_addr = {$urandom, $urandom};
    end else if (pick < ((rq.req_type == REQ_UNMAP) ? 75 : 25) && mapped_vas.size() > 0) begin
      // revisit an address mapped earlier
      rq.virt_addr = mapped_vas[$urandom_range(0, mapped_vas.size() - 1)];
    end else begin
      rq.virt_addr = {7'($urandom), hot_index(), hot_index(), hot_index(), hot_index(),
                      9'($urandom), 12'($urandom)};
    end
    if (rq.req_type == REQ_MAP) begin
      mapped_vas.push_back(rq.virt_addr);
      if (mapped_vas.size() > 64) void'(mapped_vas.pop_front());
    end
    return rq;
  endfunction

  // request side: random gap (none in steady phases), then hold the beat until it is taken
  task automatic send_request(input req_t rq, input logic fixed, input rsp_t fixed_rsp);
    int unsigned gap;
    rsp_t        predicted;
    gap = steady_flow ? 0 : $urandom_range(0, 4);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= rq;
    do @(posedge clk); while (!in_ready);
    predicted = walk_request(rq);
    // typed-in rows are checked against the table value, the shadow still advances
    walk_outcomes.push_back(fixed ? fixed_rsp : predicted);
    if (rq.req_type == REQ_MAP) maps_sent++;
    else unmaps_sent++;
  endtask

  // stop sending and wait for every outstanding result beat, then let the walker settle
  task automatic drain_requests();
    @(negedge clk);
    in_valid <= 1'b0;
    while (walk_outcomes.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // apb write of the levels register, then read it back
  task automatic write_levels(input logic [2:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_LEVELS, 2'b00};
    pwdata  <= 32'(val);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    levels_shadow = val;
    level_writes++;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    psel    <= 1'b1;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[2:0] !== val)
      report_failure($sformatf("levels read back %0d, written %0d", prdata[2:0], val));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // result side: random stall per beat, some phases with ready held high
  initial begin
    int unsigned stall;
    forever begin
      stall = steady_flow ? 0 : $urandom_range(0, 4);
      repeat (stall) begin
        @(negedge clk);
        out_ready <= 1'b0;
      end
      @(negedge clk);
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // result checker: oldest expectation first, field by field
  always @(posedge clk) begin
    rsp_t want;
    if (rst_n && out_valid && out_ready) begin
      if (walk_outcomes.size() == 0) begin
        report_failure($sformatf("result beat with nothing outstanding: ok %0b inv %0b addr %h",
                                 out_data.ok, out_data.invalidate, out_data.invalidate_addr));
      end else begin
        want = walk_outcomes.pop_front();
        if (out_data.ok !== want.ok || out_data.invalidate !== want.invalidate ||
            out_data.invalidate_addr !== want.invalidate_addr)
          report_failure($sformatf("expected ok %0b inv %0b addr %h, got ok %0b inv %0b addr %h",
                                   want.ok, want.invalidate, want.invalidate_addr,
                                   out_data.ok, out_data.invalidate, out_data.invalidate_addr));
        if (out_data.ok === 1'b0) failed_walks++;
        if (out_data.invalidate === 1'b1) invalidates_seen++;
      end
    end
  end

  initial begin
    plan_row_t row;
    logic [2:0] phase_levels;
    for (int s = 0; s < PAGE_COUNT * ENTRIES_PER_TABLE; s++) tbl_pool[s] = '0;

    // reset held low from time zero, released at a falling edge
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table
    //      lvl  kind       virt_addr              phys_addr           w  wt fix ok inv addr
    // unmap on empty tables does nothing
    add_row(4,  REQ_UNMAP, 64'h0,                 64'h0,               0, 0, 1, 1, 0, '0);
    add_row(-1, REQ_MAP,   64'h0,                 64'h0,               0, 0, 1, 1, 1, '0);
    // top of the canonical range, all-ones leaf value
    add_row(-1, REQ_MAP,   64'hFFFF_FFFF_FFFF_F000, 64'hFFFF_FFFF_FFFF_FFFF, 1, 1,
            1, 1, 1, 57'h0_FFFF_FFFF_F000);
    add_row(-1, REQ_MAP,   64'h0000_7FFF_FFFF_FFFF, 64'h1234_5000,     1, 0, 0, 0, 0, '0);
    // shares the read-only tables of va 0: rw upgrade on the way down
    add_row(-1, REQ_MAP,   64'h1000,              64'hABC0_0000,       1, 0, 0, 0, 0, '0);
    add_row(-1, REQ_MAP,   64'h2000,              64'h0,               0, 1, 0, 0, 0, '0);
    add_row(-1, REQ_UNMAP, 64'h0,                 64'hDEAD_BEEF_0000,  0, 0, 1, 1, 1, '0);
    // leaf already clear, tables still present
    add_row(-1, REQ_UNMAP, 64'h0,                 64'h0,               0, 0, 0, 0, 0, '0);
    add_row(-1, REQ_UNMAP, 64'h0000_8000_0000_0000, 64'h0,             0, 0, 1, 1, 0, '0);
    add_row(-1, REQ_MAP,   64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 0, 1,
            0, 0, 0, '0);
    add_row(-1, REQ_MAP,   64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 1, 0,
            0, 0, 0, '0);
    // five levels: the walk lands on the old all-ones leaf, frame outside the pool
    add_row(5,  REQ_MAP,   64'hFFFF_FFFF_FFFF_F000, 64'h0,             1, 0, 1, 0, 0, '0);
    add_row(-1, REQ_UNMAP, 64'hFFFF_FFFF_FFFF_F000, 64'h0,             0, 0, 1, 0, 0, '0);
    add_row(-1, REQ_MAP,   64'h0100_0000_0000_0000, 64'h7000,          1, 1, 0, 0, 0, '0);
    add_row(-1, REQ_UNMAP, 64'h0100_0000_0000_0000, 64'h0,             0, 0,
            1, 1, 1, 57'h100_0000_0000_0000);
    // bits above 56 dropped, walk hits a leaf table slot that was cleared
    add_row(-1, REQ_MAP,   64'hFE00_0000_0000_0000, 64'h8000_0000_0000_0000, 0, 0,
            0, 0, 0, '0);
    // levels 0 and 7 behave as four levels
    add_row(0,  REQ_MAP,   64'h0000_8000_0000_0000, 64'h0FFF,          1, 0, 0, 0, 0, '0);
    add_row(7,  REQ_UNMAP, 64'h0000_8000_0000_0000, 64'h0,             0, 0,
            1, 1, 1, 57'h0_8000_0000_0000);
    add_row(-1, REQ_MAP,   64'h0000_8000_0000_1000, 64'h0,             0, 1, 0, 0, 0, '0);

    foreach (directed_plan[k]) begin
      row = directed_plan[k];
      if (row.levels_sel >= 0) begin
        drain_requests();
        write_levels(3'(row.levels_sel));
      end
      send_request(row.rq, row.fixed, row.fixed_rsp);
    end

    // random phases, one level setting each; every third phase runs without gaps
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: phase_levels = 3'd5;
        1: phase_levels = 3'd4;
        2: phase_levels = 3'd7;
        3: phase_levels = 3'd0;
        4: phase_levels = 3'd5;
        5: phase_levels = 3'd2;
        6: phase_levels = 3'd5;
        7: phase_levels = 3'd6;
        default: phase_levels = 3'd4;
      endcase
      drain_requests();
      steady_flow = (p % 3 == 2);
      write_levels(phase_levels);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // hold off mid-phase until the walker has emptied
        if (p == 1 && i == PHASE_ITEMS / 2) drain_requests();
        send_request(draw_request(), 1'b0, '0);
      end
    end

    drain_requests();
    repeat (30) @(posedge clk);
    if (walk_outcomes.size() != 0)
      report_failure($sformatf("%0d results never arrived", walk_outcomes.size()));

    $display("covered %0d maps and %0d unmaps under %0d level writes (extremes 0 and 7 included)",
             maps_sent, unmaps_sent, level_writes);
    $display("saw %0d invalidates and %0d failed walks, %0d mismatches, %0d tables allocated",
             invalidates_seen, failed_walks, error_count, next_page - 1);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/ptme_pkg.sv
rtl/ptme_ram.sv
rtl/page_table_map_unmap_engine_top.sv
test/tb_page_table_map_unmap_engine_top.sv
